### src/sih_pkg.sv
package sih_pkg;

	localparam int WINDOW_STRIPES = 1024;
	localparam int TYPE_COUNT     = 32;

	localparam int WIN_W    = (WINDOW_STRIPES > 1) ? $clog2(WINDOW_STRIPES) : 1;
	localparam int TYPE_W   = 5;
	localparam int BLK_W    = 48;
	localparam int IDX_W    = 10;
	localparam int CFG_W    = 32;
	localparam int CNT_W    = 32;
	localparam int TOT_W    = 64;
	localparam int SIZE_W   = BLK_W + 1;
	localparam int CIDX_W   = 2;
	localparam int DIV_CNT_W = $clog2(BLK_W + 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CIDX_W-1:0] REG_BPS   = 2'd0;
	localparam logic [CIDX_W-1:0] REG_FIRST = 2'd1;
	localparam logic [CIDX_W-1:0] REG_MASK  = 2'd2;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FILTERED = 2'd1,
		ST_OUTSIDE  = 2'd2,
		ST_REVERSED = 2'd3
	} status_t;

	typedef struct packed {
		logic [CFG_W-1:0] bps;
		logic [CFG_W-1:0] first_stripe;
		logic [CFG_W-1:0] type_mask;
	} cfg_t;

	// one classified item handed from front to back
	typedef struct packed {
		logic              readout;
		logic              account;
		status_t           status;
		logic [IDX_W-1:0]  idx;
		logic [BLK_W-1:0]  qf;
		logic [BLK_W-1:0]  ql;
		logic [CFG_W-1:0]  rf;
		logic [CFG_W-1:0]  rl;
		logic [SIZE_W-1:0] size;
	} cmd_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_SETUP,
		B_READ,
		B_RDATA,
		B_WRD,
		B_WWR,
		B_OUT
	} back_state_t;

	function automatic logic [CFG_W-1:0] eff_bps(input logic [CFG_W-1:0] bps);
		return (bps == '0) ? CFG_W'(1) : bps;
	endfunction

	function automatic logic [TOT_W-1:0] sat_add64(input logic [TOT_W-1:0] a,
			input logic [TOT_W-1:0] b);
		logic [TOT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TOT_W] ? '1 : s[TOT_W-1:0];
	endfunction

endpackage

### src/sih_in_if.sv
interface sih_in_if;
	import sih_pkg::*;

	logic              valid;
	logic              ready;
	logic              mode;
	logic [TYPE_W-1:0] request_type;
	logic [BLK_W-1:0]  start_block;
	logic [BLK_W-1:0]  end_block;
	logic [IDX_W-1:0]  counter_index;

	modport source(output valid, mode, request_type, start_block, end_block, counter_index,
		input ready);
	modport sink(input valid, mode, request_type, start_block, end_block, counter_index,
		output ready);
endinterface

### src/sih_out_if.sv
interface sih_out_if;
	import sih_pkg::*;

	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic [CNT_W-1:0] stripe_blocks;
	logic [TOT_W-1:0] request_total;
	logic [TOT_W-1:0] block_total;
	logic [TOT_W-1:0] split_total;
	logic [CNT_W-1:0] smallest_request;
	logic [CNT_W-1:0] largest_request;

	modport source(output valid, status, stripe_blocks, request_total, block_total,
		split_total, smallest_request, largest_request, input ready);
	modport sink(input valid, status, stripe_blocks, request_total, block_total,
		split_total, smallest_request, largest_request, output ready);
endinterface

### src/sih_ram.sv
module sih_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### src/sih_div.sv
module sih_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [sih_pkg::BLK_W-1:0] dividend,
	input  logic [sih_pkg::CFG_W-1:0] divisor,
	output logic                      busy,
	output logic [sih_pkg::BLK_W-1:0] quot,
	output logic [sih_pkg::CFG_W-1:0] rem
);
	import sih_pkg::*;

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [BLK_W-1:0]     quot_q;
	logic [CFG_W-1:0]     rem_q;
	logic [CFG_W-1:0]     dvs_q;
	logic [CFG_W:0]       trial;
	logic                 take;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quot_q[BLK_W-1]};
	assign take  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(BLK_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[BLK_W-2:0], take};
			rem_q  <= take ? CFG_W'(trial - {1'b0, dvs_q}) : trial[CFG_W-1:0];
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;
	assign rem  = rem_q;
endmodule

### src/sih_front.sv
module sih_front (
	input  logic          clk,
	input  logic          arst_n,
	sih_in_if.sink        in_ch,
	input  sih_pkg::cfg_t cfg,
	input  logic          clearing,
	input  logic          q_full,
	output logic          push,
	output sih_pkg::cmd_t cmd
);
	import sih_pkg::*;

	front_state_t     state_q, state_d;
	cmd_t             cmd_q;
	logic             accept;
	logic             pass;
	logic             is_acc;
	logic             busy_a, busy_b;
	logic [BLK_W-1:0] quot_a, quot_b;
	logic [CFG_W-1:0] rem_a, rem_b;
	logic [CFG_W-1:0] bps;

	assign bps  = eff_bps(cfg.bps);
	assign pass = (cfg.type_mask == '0)
		|| (({2'b00, in_ch.request_type} < 7'(TYPE_COUNT))
		&& cfg.type_mask[in_ch.request_type]);
	assign is_acc = !in_ch.mode && pass && (in_ch.start_block <= in_ch.end_block);

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					state_d = is_acc ? F_DIV : F_PUSH;
				end
			end
			F_DIV: begin
				if (!busy_a && !busy_b) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				if (!q_full) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready = 1'b0;
		push        = 1'b0;
		case (state_q)
			F_IDLE:  in_ch.ready = !clearing;
			F_PUSH:  push = !q_full;
			default: ;
		endcase
	end

	assign accept = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q.readout <= in_ch.mode;
			cmd_q.account <= is_acc;
			cmd_q.idx     <= in_ch.counter_index;
			cmd_q.qf      <= '0;
			cmd_q.ql      <= '0;
			cmd_q.rf      <= '0;
			cmd_q.rl      <= '0;
			cmd_q.size    <= {1'b0, in_ch.end_block} - {1'b0, in_ch.start_block}
				+ SIZE_W'(1);
			if (in_ch.mode) begin
				cmd_q.status <= (32'(in_ch.counter_index) >= WINDOW_STRIPES)
					? ST_OUTSIDE : ST_OK;
			end else if (!pass) begin
				cmd_q.status <= ST_FILTERED;
			end else if (!is_acc) begin
				cmd_q.status <= ST_REVERSED;
			end else begin
				cmd_q.status <= ST_OK;
			end
		end
	end

	sih_div u_div_first (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && is_acc),
		.dividend (in_ch.start_block),
		.divisor  (bps),
		.busy     (busy_a),
		.quot     (quot_a),
		.rem      (rem_a)
	);

	sih_div u_div_last (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && is_acc),
		.dividend (in_ch.end_block),
		.divisor  (bps),
		.busy     (busy_b),
		.quot     (quot_b),
		.rem      (rem_b)
	);

	always_comb begin
		cmd    = cmd_q;
		cmd.qf = quot_a;
		cmd.ql = quot_b;
		cmd.rf = rem_a;
		cmd.rl = rem_b;
	end
endmodule

### src/sih_queue.sv
module sih_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sih_pkg::cmd_t din,
	output logic          full,
	input  logic          pop,
	output sih_pkg::cmd_t dout,
	output logic          empty
);
	import sih_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = cnt_q == QCNT_W'(QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end
endmodule

### src/sih_back.sv
module sih_back (
	input  logic          clk,
	input  logic          arst_n,
	input  sih_pkg::cfg_t cfg,
	input  logic          q_empty,
	input  sih_pkg::cmd_t q_data,
	output logic          q_pop,
	output logic          clearing,
	sih_out_if.source     out_ch
);
	import sih_pkg::*;

	back_state_t      state_q, state_d;
	logic [WIN_W-1:0] clr_q;
	cmd_t             cmd_q;
	logic [BLK_W-1:0] cur_q, hi_q;
	status_t          status_q;
	logic [CNT_W-1:0] readval_q;
	logic [TOT_W-1:0] req_q, blk_q, spl_q;
	logic [CNT_W-1:0] min_q, max_q;
	logic             out_valid_q;
	logic             out_load;

	logic             ram_we;
	logic [WIN_W-1:0] ram_waddr, ram_raddr, slot;
	logic [CNT_W-1:0] ram_wdata, ram_rdata;

	logic [BLK_W-1:0] w_lo, w_hi, lo, hi;
	logic             outside;
	logic [CFG_W-1:0] bps;
	logic [CNT_W-1:0] size32, overlap;
	logic [CNT_W:0]   sum;
	logic             is_first, is_last;

	assign bps     = eff_bps(cfg.bps);
	assign w_lo    = BLK_W'(cfg.first_stripe);
	assign w_hi    = w_lo + BLK_W'(WINDOW_STRIPES - 1);
	assign lo      = (cmd_q.qf > w_lo) ? cmd_q.qf : w_lo;
	assign hi      = (cmd_q.ql < w_hi) ? cmd_q.ql : w_hi;
	assign outside = (cmd_q.qf < w_lo) || (cmd_q.ql > w_hi);
	assign size32  = (cmd_q.size > SIZE_W'(32'hFFFF_FFFF)) ? '1 : cmd_q.size[CNT_W-1:0];
	assign slot    = WIN_W'(cur_q - w_lo);

	// overlap of the current stripe with the request range
	assign is_first = cur_q == cmd_q.qf;
	assign is_last  = cur_q == cmd_q.ql;
	always_comb begin
		if (is_first && is_last) begin
			overlap = cmd_q.size[CNT_W-1:0];
		end else if (is_first) begin
			overlap = bps - cmd_q.rf;
		end else if (is_last) begin
			overlap = cmd_q.rl + CNT_W'(1);
		end else begin
			overlap = bps;
		end
	end
	assign sum = {1'b0, ram_rdata} + {1'b0, overlap};

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_CLEAR: begin
				if (clr_q == WIN_W'(WINDOW_STRIPES - 1)) begin
					state_d = B_IDLE;
				end
			end
			B_IDLE: begin
				if (!q_empty) begin
					state_d = B_SETUP;
				end
			end
			B_SETUP: begin
				if (cmd_q.readout) begin
					state_d = (cmd_q.status == ST_OK) ? B_READ : B_OUT;
				end else if (cmd_q.account && (lo <= hi)) begin
					state_d = B_WRD;
				end else begin
					state_d = B_OUT;
				end
			end
			B_READ:  state_d = B_RDATA;
			B_RDATA: state_d = B_OUT;
			B_WRD:   state_d = B_WWR;
			B_WWR:   state_d = (cur_q == hi_q) ? B_OUT : B_WRD;
			B_OUT: begin
				if (out_load) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot;
		ram_wdata = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
		ram_raddr = slot;
		q_pop     = 1'b0;
		out_load  = 1'b0;
		clearing  = 1'b0;
		case (state_q)
			B_CLEAR: begin
				clearing  = 1'b1;
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			B_IDLE:  q_pop = !q_empty;
			B_READ:  ram_raddr = WIN_W'(cmd_q.idx);
			B_WWR:   ram_we = 1'b1;
			B_OUT:   out_load = !out_valid_q || out_ch.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_q       <= '0;
			req_q       <= '0;
			blk_q       <= '0;
			spl_q       <= '0;
			min_q       <= '0;
			max_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == B_SETUP && !cmd_q.readout && cmd_q.account) begin
				req_q <= sat_add64(req_q, TOT_W'(1));
				blk_q <= sat_add64(blk_q, TOT_W'(cmd_q.size));
				spl_q <= sat_add64(spl_q, TOT_W'(cmd_q.ql - cmd_q.qf));
				if (min_q == '0 || size32 < min_q) begin
					min_q <= size32;
				end
				if (size32 > max_q) begin
					max_q <= size32;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					cmd_q <= q_data;
				end
			end
			B_SETUP: begin
				readval_q <= '0;
				cur_q     <= lo;
				hi_q      <= hi;
				if (!cmd_q.readout && cmd_q.account) begin
					status_q <= outside ? ST_OUTSIDE : ST_OK;
				end else begin
					status_q <= cmd_q.status;
				end
			end
			B_RDATA: readval_q <= ram_rdata;
			B_WWR:   cur_q <= cur_q + 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ch.status           <= status_q;
			out_ch.stripe_blocks    <= readval_q;
			out_ch.request_total    <= req_q;
			out_ch.block_total      <= blk_q;
			out_ch.split_total      <= spl_q;
			out_ch.smallest_request <= min_q;
			out_ch.largest_request  <= max_q;
		end
	end

	assign out_ch.valid = out_valid_q;

	sih_ram #(
		.WIDTH (CNT_W),
		.DEPTH (WINDOW_STRIPES)
	) u_counters (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);
endmodule

### src/stripe_io_histogram.sv
// stripe_io_histogram: per-stripe block counters and running request totals
//
// req_ch takes one beat per request: mode 0 accounts an inclusive block range,
// mode 1 reads one stripe counter. res_ch gives exactly one beat per request
// with the status, the counter read (zero otherwise) and a snapshot of totals.
// cfg_we/cfg_index/cfg_wdata write blocks_per_stripe (0), first_stripe (1)
// and type_mask (2); write them only while no request is in flight.
//
// a front stage classifies each beat and runs two dividers for the stripe
// numbers of the first and last block; a two-entry queue feeds the back stage,
// which walks the stripe counter RAM, reading and then writing back each stripe
// touched inside the window. the front divides the next request while the back
// walks the current one. readouts and refused beats skip the dividers.
//
// after reset the counter RAM is cleared, one entry a cycle, and req_ch.ready
// stays low meanwhile. a stalled res_ch holds its beat in the output register
// while the back stage works up to its next result and the queue fills.
module stripe_io_histogram (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [sih_pkg::CIDX_W-1:0] cfg_index,
	input  logic [sih_pkg::CFG_W-1:0]  cfg_wdata,
	sih_in_if.sink                     req_ch,
	sih_out_if.source                  res_ch
);
	import sih_pkg::*;

	cfg_t cfg_q;
	logic clearing;
	logic q_push, q_pop, q_full, q_empty;
	cmd_t q_din, q_dout;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bps          <= CFG_W'(1024);
			cfg_q.first_stripe <= '0;
			cfg_q.type_mask    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BPS:   cfg_q.bps <= cfg_wdata;
				REG_FIRST: cfg_q.first_stripe <= cfg_wdata;
				REG_MASK:  cfg_q.type_mask <= cfg_wdata;
				default:   ;
			endcase
		end
	end

	sih_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (req_ch),
		.cfg      (cfg_q),
		.clearing (clearing),
		.q_full   (q_full),
		.push     (q_push),
		.cmd      (q_din)
	);

	sih_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	sih_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_data   (q_dout),
		.q_pop    (q_pop),
		.clearing (clearing),
		.out_ch   (res_ch)
	);

	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !(req_ch.valid && req_ch.ready))
		else $error("request accepted during counter clear");

	a_no_result_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !res_ch.valid)
		else $error("result beat during counter clear");

	a_queue_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue push while full");

	a_queue_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue pop while empty");
endmodule
